// ===== src/srl_pkg.sv =====
// ----------------------------------------------------------------------------
// srl_pkg
// Shared types, codes and character helpers for the S-record stream loader.
// ----------------------------------------------------------------------------
package srl_pkg;

    // Parser phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SKIP  = 3'd1;
    localparam logic [2:0] PH_TYPE  = 3'd2;
    localparam logic [2:0] PH_COUNT = 3'd3;
    localparam logic [2:0] PH_ADDR  = 3'd4;
    localparam logic [2:0] PH_BODY  = 3'd5;

    // Event kinds
    localparam logic [1:0] EV_WRITE    = 2'd0;
    localparam logic [1:0] EV_START    = 2'd1;
    localparam logic [1:0] EV_MISMATCH = 2'd2;

    // Register map
    localparam int unsigned PADDR_W = 3;
    localparam logic        REG_LOAD_OFFSET = 1'b0;   // word index of load_offset

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [31:0] address;
        logic [7:0]  data;
        logic [15:0] count;
    } result_t;

    // Address length in bytes for a type digit; zero marks an unsupported type.
    function automatic logic [2:0] addr_len(input logic [3:0] rtype);
        logic [2:0] len;
        begin
            unique case (rtype)
                4'd0, 4'd1, 4'd5, 4'd9: len = 3'd2;
                4'd2, 4'd8:             len = 3'd3;
                4'd3, 4'd7:             len = 3'd4;
                default:                len = 3'd0;
            endcase
            return len;
        end
    endfunction

    // Returns {is_hex, nibble}.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] v;
        logic       ok;
        begin
            v  = 8'd0;
            ok = 1'b0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                v  = c - 8'h30;
                ok = 1'b1;
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                v  = c - 8'h37;
                ok = 1'b1;
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                v  = c - 8'h57;
                ok = 1'b1;
            end
            return {ok, v[3:0]};
        end
    endfunction

endpackage

// ===== src/srl_parser.sv =====
// ----------------------------------------------------------------------------
// srl_parser
// Per-character S-record parse state and the event that one character causes.
// ----------------------------------------------------------------------------
module srl_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      char_in,
    input  logic [31:0]     load_offset,
    output srl_pkg::result_t result
);
    import srl_pkg::*;

    logic [2:0]  phase_reg,     phase_next;
    logic [3:0]  rtype_reg,     rtype_next;
    logic [7:0]  left_reg,      left_next;
    logic [2:0]  abl_reg,       abl_next;
    logic [3:0]  high_reg,      high_next;
    logic        pending_reg,   pending_next;
    logic [31:0] raddr_reg,     raddr_next;
    logic [15:0] count_reg,     count_next;

    logic        eol;
    logic [4:0]  hx;
    logic [7:0]  byte_val;
    logic [2:0]  type_len;
    logic        is_digit;
    logic        data_type;

    always_comb
    begin
        eol       = (char_in == 8'h0A) || (char_in == 8'h0D);
        hx        = hex_decode(char_in);
        byte_val  = {high_reg, hx[3:0]};
        is_digit  = (char_in >= 8'h30) && (char_in <= 8'h39);
        type_len  = addr_len(char_in[3:0]);
        data_type = (rtype_reg >= 4'd1) && (rtype_reg <= 4'd3);

        phase_next   = phase_reg;
        rtype_next   = rtype_reg;
        left_next    = left_reg;
        abl_next     = abl_reg;
        high_next    = high_reg;
        pending_next = pending_reg;
        raddr_next   = raddr_reg;
        count_next   = count_reg;

        result         = '0;
        result.count   = count_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (char_in == 8'h53)
                    phase_next = PH_TYPE;
                else if (!eol)
                    phase_next = PH_SKIP;
            end
            PH_TYPE:
            begin
                if (is_digit && type_len != 3'd0)
                begin
                    rtype_next   = char_in[3:0];
                    abl_next     = type_len;
                    pending_next = 1'b0;
                    raddr_next   = '0;
                    phase_next   = PH_COUNT;
                end
                else
                    phase_next = eol ? PH_IDLE : PH_SKIP;
            end
            PH_COUNT, PH_ADDR, PH_BODY:
            begin
                if (!hx[4])
                begin
                    // abandon the record
                    pending_next = 1'b0;
                    phase_next   = eol ? PH_IDLE : PH_SKIP;
                end
                else if (!pending_reg)
                begin
                    high_next    = hx[3:0];
                    pending_next = 1'b1;
                end
                else
                begin
                    pending_next = 1'b0;
                    if (phase_reg == PH_COUNT)
                    begin
                        if ({1'b0, byte_val} < ({6'd0, abl_reg} + 9'd1))
                            phase_next = PH_SKIP;
                        else
                        begin
                            left_next  = byte_val - {5'd0, abl_reg};
                            phase_next = PH_ADDR;
                        end
                    end
                    else if (phase_reg == PH_ADDR)
                    begin
                        raddr_next = {raddr_reg[23:0], byte_val};
                        abl_next   = abl_reg - 3'd1;
                        if (abl_reg == 3'd1)
                            phase_next = PH_BODY;
                    end
                    else if (left_reg <= 8'd1)
                    begin
                        // checksum byte: close the record
                        phase_next = PH_SKIP;
                        if (data_type)
                        begin
                            if (count_reg != COUNT_MAX)
                                count_next = count_reg + 16'd1;
                        end
                        else if (rtype_reg == 4'd5)
                        begin
                            if (raddr_reg[15:0] != count_reg)
                            begin
                                result.valid   = 1'b1;
                                result.kind    = EV_MISMATCH;
                                result.address = raddr_reg;
                            end
                        end
                        else if (rtype_reg >= 4'd7)
                        begin
                            result.valid   = 1'b1;
                            result.kind    = EV_START;
                            result.address = raddr_reg;
                        end
                    end
                    else
                    begin
                        left_next = left_reg - 8'd1;
                        if (data_type)
                        begin
                            result.valid   = 1'b1;
                            result.kind    = EV_WRITE;
                            result.address = raddr_reg + load_offset;
                            result.data    = byte_val;
                            raddr_next     = raddr_reg + 32'd1;
                        end
                    end
                end
            end
            default:
                phase_next = eol ? PH_IDLE : PH_SKIP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            rtype_reg   <= '0;
            left_reg    <= '0;
            abl_reg     <= '0;
            high_reg    <= '0;
            pending_reg <= 1'b0;
            raddr_reg   <= '0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            rtype_reg   <= rtype_next;
            left_reg    <= left_next;
            abl_reg     <= abl_next;
            high_reg    <= high_next;
            pending_reg <= pending_next;
            raddr_reg   <= raddr_next;
            count_reg   <= count_next;
        end
    end

    // The record counter never moves backward.
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= $past(count_reg))
        else $error("record counter decreased");

    // After the last address byte the body phase starts with abl_reg at zero.
    a_body_after_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_ADDR && pending_reg && hx[4] && abl_reg == 3'd1)
        |=> (phase_reg == PH_BODY && abl_reg == 3'd0))
        else $error("address phase did not hand over to body");

    // An event is only produced from the body phase.
    a_event_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (phase_reg == PH_BODY && pending_reg))
        else $error("event outside body phase");

endmodule

// ===== src/srecord_stream_loader.sv =====
// ----------------------------------------------------------------------------
// srecord_stream_loader
// Motorola S-record decoder: ASCII characters in, memory writes, start
// address and record-count checks out.
// ----------------------------------------------------------------------------
// Feed the S-record text one character per request on char_in; one character
// is taken every clock cycle as long as the two-entry output buffer has room,
// and each character is fully parsed in the cycle it is taken; its event is
// registered into the output buffer. Lines starting with 'S' are
// decoded: S1/S2/S3 data bytes come out as memory byte writes at the record
// address plus load_offset (event_kind 0), S7/S8/S9 give the start address
// (kind 1), and S5 reports a count mismatch (kind 2) when its stated count
// differs from the saturating count of data records. The checksum byte is
// consumed but not checked; a non-hex character abandons the record. Program
// load_offset (byte address 0) only while the stream is idle.
module srecord_stream_loader (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB-style configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srl_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // character input
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  char_in,
    // event output
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  event_kind,
    output logic [31:0]                 address,
    output logic [7:0]                  data_byte,
    output logic [15:0]                 records_seen
);
    import srl_pkg::*;

    logic [31:0] load_offset_reg;
    logic        cfg_write;

    logic        in_accept;
    logic        out_pop;
    logic        push;
    result_t     result;

    // output buffer: head entry drives the ports, skid entry catches a result
    // produced while the head is stalled
    result_t     head_reg,       head_next;
    logic        head_valid_reg, head_valid_next;
    result_t     skid_reg,       skid_next;
    logic        skid_valid_reg, skid_valid_next;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[PADDR_W-1] == REG_LOAD_OFFSET) ? load_offset_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_offset_reg <= '0;
        else if (cfg_write && paddr[PADDR_W-1] == REG_LOAD_OFFSET)
            load_offset_reg <= pwdata;
    end

    // ---------------- parse ----------------
    // Hold off input only when the skid entry is full; the stall is a pure
    // register output.
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;

    srl_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .char_in     (char_in),
        .load_offset (load_offset_reg),
        .result      (result)
    );

    assign push    = in_accept && result.valid;
    assign out_pop = head_valid_reg && !out_stall;

    // ---------------- output buffer ----------------
    always_comb
    begin
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (out_pop)
        begin
            // advance: skid moves up, else a fresh result, else drain
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
                head_next = result;
            else
                head_valid_next = 1'b0;
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_next       = result;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = head_valid_reg;
    assign event_kind   = head_reg.kind;
    assign address      = head_reg.address;
    assign data_byte    = head_reg.data;
    assign records_seen = head_reg.count;

    // ---------------- checks ----------------
    a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry held with empty head");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_pop && !skid_valid_reg && !push) |=> !head_valid_reg)
        else $error("head not drained after pop");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid_reg && head_reg.kind != EV_WRITE) |-> (head_reg.data == 8'd0))
        else $error("nonzero data on a non-write event");

    a_skid_promote: assert property (@(posedge clk) disable iff (!rst_n)
        (out_pop && skid_valid_reg) |=> (head_valid_reg && !skid_valid_reg))
        else $error("skid entry not promoted on pop");

endmodule
